/* sv/clf_pkg.sv */
// ----------------------------------------------------------------------------
// clf_pkg
// Shared constants and types for the CRLF line framer.
// ----------------------------------------------------------------------------
package clf_pkg;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam int LINE_LIMIT_DEF = 512;
    localparam int ITEM_BYTES_DEF = 64;

    // Widths that cover the whole supported range of ITEM_BYTES (up to 65).
    localparam int CMD_LEN_W = 7;
    localparam int WR_IDX_W  = 6;

    typedef struct packed {
        logic                 bank;
        logic [CMD_LEN_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic                en;
        logic                bank;
        logic [WR_IDX_W-1:0] idx;
        logic [7:0]          data;
    } t_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } t_bstate;

endpackage

/* sv/crlf_line_framer.sv */
// ----------------------------------------------------------------------------
// crlf_line_framer
// Frames a received byte stream into LF-terminated lines.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle while a line bank is free. On LF the
// finished line, with a trailing CR stripped and cut to ITEM_BYTES-1 bytes,
// is queued and played out byte by byte: each byte is read from the bank
// (B_READ), then presented (B_SEND) until taken, and each line is first
// popped from the queue (B_IDLE); tlast marks the final byte. Empty lines
// produce nothing. Two line banks let the next line be received while one is
// played out; input stalls only when both banks hold lines still to go out.
module crlf_line_framer
    import clf_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF,
    parameter int ITEM_BYTES = ITEM_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] line_byte
    output logic       m_axis_tlast
);

    t_wr  wr;
    logic push;
    t_cmd push_cmd;
    t_rel rel;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    clf_front #(
        .LINE_LIMIT(LINE_LIMIT),
        .ITEM_BYTES(ITEM_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_wr    (wr),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_rel   (rel)
    );

    clf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    clf_back #(
        .ITEM_BYTES(ITEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_rel       (rel),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

/* sv/clf_front.sv */
// ----------------------------------------------------------------------------
// clf_front
// Accepts received bytes, tracks the open line and queues finished lines.
// ----------------------------------------------------------------------------
module clf_front
    import clf_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF,
    parameter int ITEM_BYTES = ITEM_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    output t_wr        o_wr,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  t_rel       i_rel
);

    localparam int SD     = ITEM_BYTES - 1;
    localparam int LEN_W  = $clog2(LINE_LIMIT);
    localparam int ELEN_W = (ITEM_BYTES > 2) ? $clog2(ITEM_BYTES) : 1;
    localparam int IDX_W  = (SD > 1) ? $clog2(SD) : 1;
    localparam int CW     = (LEN_W > ELEN_W) ? LEN_W : ELEN_W;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_cr, n_cr;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_busy, n_busy;

    logic             acc;
    logic [LEN_W-1:0] len0;
    logic             cr0;
    logic [CW-1:0]    len_x;
    logic [CW-1:0]    trim;
    logic [CW-1:0]    clamp;
    logic [ELEN_W-1:0] elen;
    logic [IDX_W-1:0] widx;

    assign o_ready = !r_busy[r_wbank];
    assign acc     = i_valid && o_ready;

    always_comb begin
        if (r_len == LEN_W'(LINE_LIMIT - 1)) begin
            len0 = '0;
            cr0  = 1'b0;
        end else begin
            len0 = r_len;
            cr0  = r_cr;
        end
        len_x = CW'(len0);
        trim  = (cr0 && (len_x != '0)) ? (len_x - CW'(1)) : len_x;
        clamp = (trim > CW'(SD)) ? CW'(SD) : trim;
        elen  = clamp[ELEN_W-1:0];
        widx  = len_x[IDX_W-1:0];
    end

    always_comb begin
        n_len   = r_len;
        n_cr    = r_cr;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_wr.en   = 1'b0;
        o_wr.bank = r_wbank;
        o_wr.idx  = WR_IDX_W'(widx);
        o_wr.data = i_data;
        o_cmd.bank = r_wbank;
        o_cmd.len  = CMD_LEN_W'(elen);
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (acc) begin
            if (i_data == CHAR_LF) begin
                n_len = '0;
                n_cr  = 1'b0;
                if (elen != '0) begin
                    o_push          = 1'b1;
                    n_busy[r_wbank] = 1'b1;
                    n_wbank         = !r_wbank;
                end
            end else begin
                o_wr.en = (len_x < CW'(SD));
                n_len   = len0 + LEN_W'(1);
                n_cr    = (i_data == CHAR_CR);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_cr    <= 1'b0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_len   <= n_len;
            r_cr    <= n_cr;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

/* sv/clf_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// clf_cmd_fifo
// Two-entry queue of finished lines between the front and the back.
// ----------------------------------------------------------------------------
module clf_cmd_fifo
    import clf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? !r_wp : r_wp;
        n_rp  = do_pop ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/clf_back.sv */
// ----------------------------------------------------------------------------
// clf_back
// Holds the two line banks and plays a queued line out byte by byte.
// ----------------------------------------------------------------------------
module clf_back
    import clf_pkg::*;
#(
    parameter int ITEM_BYTES = ITEM_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_wr        i_wr,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output t_rel       o_rel,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last
);

    localparam int SD     = ITEM_BYTES - 1;
    localparam int ELEN_W = (ITEM_BYTES > 2) ? $clog2(ITEM_BYTES) : 1;
    localparam int IDX_W  = (SD > 1) ? $clog2(SD) : 1;

    logic [7:0] mem [2][SD];

    t_bstate           r_state, n_state;
    logic              r_bank;
    logic [ELEN_W-1:0] r_len;
    logic [IDX_W-1:0]  r_idx;
    logic [7:0]        r_rdata;
    logic              rd_en;
    logic              last;

    assign last = ((ELEN_W'(r_idx) + ELEN_W'(1)) == r_len);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.bank][i_wr.idx[IDX_W-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[r_bank][r_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = B_READ;
                end
            end
            B_READ: begin
                n_state = B_SEND;
            end
            B_SEND: begin
                if (i_ready) begin
                    n_state = last ? B_IDLE : B_READ;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        rd_en       = 1'b0;
        o_valid     = 1'b0;
        o_rel.valid = 1'b0;
        o_rel.bank  = r_bank;
        case (r_state)
            B_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            B_READ: begin
                rd_en = 1'b1;
            end
            B_SEND: begin
                o_valid     = 1'b1;
                o_rel.valid = i_ready && last;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_data = r_rdata;
    assign o_last = last;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_bank <= i_cmd.bank;
            r_len  <= i_cmd.len[ELEN_W-1:0];
            r_idx  <= '0;
        end else if (o_valid && i_ready && !last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
